### rtl/core/scp_pkg.sv
`timescale 1ns / 1ps

package scp_pkg;

  // internal fixed point: 28 fractional bits
  localparam int WFRAC = 28;

  localparam int ANGLE_FRAC_BITS_DEF  = 16;
  localparam int RESULT_FRAC_BITS_DEF = 16;

  localparam logic [30:0] K_PI      = 31'd843314857;
  localparam logic [30:0] K_TWO_PI  = 31'd1686629713;
  localparam logic [30:0] K_HALF_PI = 31'd421657428;
  // 2pi - pi - 1, offset used when folding the remainder back around zero
  localparam logic [30:0] K_FOLD    = 31'd843314855;

  localparam logic [25:0] K_R6    = 26'd44739243;
  localparam logic [21:0] K_R120  = 22'd2236962;
  localparam logic [15:0] K_R5040 = 16'd53261;

  // number of register stages in the polynomial pipeline
  localparam int POLY_STAGES = 8;

  // how the reduction remainder maps back to the angle
  localparam logic [1:0] MODE_KEEP = 2'd0;
  localparam logic [1:0] MODE_POS  = 2'd1;
  localparam logic [1:0] MODE_NEG  = 2'd2;

  typedef struct packed {
    logic               vld;
    logic [1:0]         mode;
    logic signed [30:0] xs;
  } scp_tag_t;

endpackage

### rtl/core/scp_cell.sv
`timescale 1ns / 1ps

// One restoring step of the 2pi reduction: strips 2pi * 2^K if it fits.
module scp_cell #(
  parameter int UW = 44,
  parameter int K  = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scp_pkg::scp_tag_t tag_i,
  input  logic [UW-1:0]     rem_i,
  output scp_pkg::scp_tag_t tag_o,
  output logic [UW-1:0]     rem_o
);

  localparam logic [UW-1:0] DIV = UW'(scp_pkg::K_TWO_PI) << K;

  logic               vld_r;
  logic [1:0]         mode_r;
  logic signed [30:0] xs_r;
  logic [UW-1:0]      rem_r;
  logic [UW-1:0]      rem_nxt;

  always_comb begin
    if (rem_i >= DIV) begin
      rem_nxt = rem_i - DIV;
    end else begin
      rem_nxt = rem_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tag_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= tag_i.mode;
    xs_r   <= tag_i.xs;
    rem_r  <= rem_nxt;
  end

  assign tag_o = '{vld: vld_r, mode: mode_r, xs: xs_r};
  assign rem_o = rem_r;

endmodule

### rtl/core/scp_poly.sv
`timescale 1ns / 1ps

// x - x^3/6 + x^5/120 - x^7/5040 on |x|, then sign and rounding.
module scp_poly #(
  parameter int RESULT_FRAC_BITS = scp_pkg::RESULT_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  input  logic [29:0]                 m_i,
  input  logic                        neg_i,
  output logic                        vld_o,
  output logic [RESULT_FRAC_BITS+1:0] value_o
);

  localparam int OW = RESULT_FRAC_BITS + 2;
  localparam int NS = scp_pkg::POLY_STAGES;

  logic [NS-1:0] vld_r;

  // P1
  logic [59:0] p1;
  logic [29:0] m1_r;
  logic        n1_r;
  logic [31:0] x2_1_r;
  // P2
  logic [61:0] p2;
  logic [32:0] x3_2_r;
  logic [31:0] x2_2_r;
  logic [29:0] m2_r;
  logic        n2_r;
  // P3
  logic [64:0] p3a;
  logic [58:0] p3b;
  logic [36:0] x5_3_r;
  logic [31:0] x2_3_r;
  logic [29:0] m3_r;
  logic        n3_r;
  logic [30:0] t3_3_r;
  // P4
  logic [68:0]        p4a;
  logic [58:0]        p4b;
  logic signed [32:0] sa;
  logic [39:0]        x7_4_r;
  logic [29:0]        t5_4_r;
  logic signed [32:0] sa_4_r;
  logic               n4_r;
  // P5
  logic [55:0]        p5;
  logic [27:0]        t7_5_r;
  logic signed [32:0] s1_5_r;
  logic               n5_r;
  // P6
  logic signed [32:0] sd_6_r;
  logic               n6_r;
  // P7
  logic [31:0] mag_nxt;
  logic [31:0] mag_7_r;
  logic        sn_7_r;
  // P8
  logic [OW-1:0] rnd;
  logic [OW-1:0] value_r;

  assign p1  = m_i * m_i;
  assign p2  = x2_1_r * m1_r;
  assign p3a = x3_2_r * x2_2_r;
  assign p3b = x3_2_r * scp_pkg::K_R6;
  assign p4a = x5_3_r * x2_3_r;
  assign p4b = x5_3_r * scp_pkg::K_R120;
  assign sa  = $signed({3'b000, m3_r}) - $signed({2'b00, t3_3_r});
  assign p5  = x7_4_r * scp_pkg::K_R5040;

  always_comb begin
    if (sd_6_r[32]) begin
      mag_nxt = 32'(-sd_6_r);
    end else begin
      mag_nxt = sd_6_r[31:0];
    end
  end

  // round to nearest, ties away from zero, on the magnitude
  if (RESULT_FRAC_BITS < scp_pkg::WFRAC) begin : g_rnd
    localparam int SH = scp_pkg::WFRAC - RESULT_FRAC_BITS;
    logic [32:0] sum;
    assign sum = {1'b0, mag_7_r} + (33'd1 << (SH - 1));
    assign rnd = OW'(sum >> SH);
  end else begin : g_shl
    assign rnd = OW'(34'(mag_7_r) << (RESULT_FRAC_BITS - scp_pkg::WFRAC));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    m1_r    <= m_i;
    n1_r    <= neg_i;
    x2_1_r  <= p1[59:28];

    x3_2_r  <= p2[60:28];
    x2_2_r  <= x2_1_r;
    m2_r    <= m1_r;
    n2_r    <= n1_r;

    x5_3_r  <= p3a[64:28];
    x2_3_r  <= x2_2_r;
    m3_r    <= m2_r;
    n3_r    <= n2_r;
    t3_3_r  <= p3b[58:28];

    x7_4_r  <= p4a[67:28];
    t5_4_r  <= p4b[57:28];
    sa_4_r  <= sa;
    n4_r    <= n3_r;

    t7_5_r  <= p5[55:28];
    s1_5_r  <= sa_4_r + $signed({3'b000, t5_4_r});
    n5_r    <= n4_r;

    sd_6_r  <= s1_5_r - $signed({5'b00000, t7_5_r});
    n6_r    <= n5_r;

    // result sign: term sum sign flipped when the reduced angle was negative
    mag_7_r <= mag_nxt;
    sn_7_r  <= (sd_6_r != '0) && (sd_6_r[32] ^ n6_r);

    value_r <= sn_7_r ? (OW'(0) - rnd) : rnd;
  end

  assign vld_o   = vld_r[NS-1];
  assign value_o = value_r;

endmodule

### rtl/core/sine_cosine_polynomial_core.sv
`timescale 1ns / 1ps

// channel   ports                               handshake
// input     in_req_type, in_angle               start high and busy low
// result    out_value                           out_valid strobe, one cycle
//
// One angle per clock while busy is low. The pipeline is two input stages,
// one reduction cell per quotient bit of the 2pi reduction
// (30 - ANGLE_FRAC_BITS cells), one fold stage and the eight-stage
// multiply pipeline of the polynomial.
// rst_n is synchronous and clears the valid bits only; busy is high while
// rst_n is low. The receiver cannot stall, so nothing in the block ever does.
module sine_cosine_polynomial_core #(
  parameter int ANGLE_FRAC_BITS  = scp_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int RESULT_FRAC_BITS = scp_pkg::RESULT_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic signed [31:0]          in_angle,
  output logic                        out_valid,
  output logic [RESULT_FRAC_BITS+1:0] out_value
);

  localparam int SHL = scp_pkg::WFRAC - ANGLE_FRAC_BITS;
  localparam int XW  = 61 - ANGLE_FRAC_BITS;
  localparam int UW  = XW - 1;
  localparam int NQ  = 30 - ANGLE_FRAC_BITS;
  localparam int LAT = NQ + 3 + scp_pkg::POLY_STAGES;

  localparam logic signed [XW-1:0] PI_X   = XW'(scp_pkg::K_PI);
  localparam logic signed [XW-1:0] NPI_X  = -PI_X;
  localparam logic signed [XW-1:0] PI_P1  = PI_X + XW'(1);
  localparam logic signed [XW-1:0] NPI_M1 = NPI_X - XW'(1);
  localparam logic signed [XW-1:0] HPI_X  = XW'(scp_pkg::K_HALF_PI);

  logic accept;

  // stage 0: widen to 28 fractional bits, cosine offset
  logic signed [XW-1:0] ang_ext;
  logic signed [XW-1:0] x_nxt;
  logic signed [XW-1:0] x_r;
  logic                 v0_r;

  // stage 1: classify and build the non-negative dividend
  logic                 gt;
  logic                 lt;
  logic signed [XW-1:0] diff;
  logic [UW-1:0]        u_nxt;
  logic [1:0]           mode_nxt;
  logic [UW-1:0]        u_r;
  logic [1:0]           mode1_r;
  logic signed [30:0]   xs1_r;
  logic                 v1_r;

  scp_pkg::scp_tag_t tag_c [NQ+1];
  logic [UW-1:0]     rem_c [NQ+1];

  // fold stage
  scp_pkg::scp_tag_t  ftag;
  logic [30:0]        rem_f;
  logic               lo;
  logic [30:0]        dcm;
  logic [29:0]        m_nxt;
  logic               neg_nxt;
  logic [29:0]        m_r;
  logic               neg_r;
  logic               fv_r;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  assign ang_ext = XW'(in_angle);
  assign x_nxt   = (ang_ext <<< SHL) + (in_req_type ? HPI_X : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      fv_r <= 1'b0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
      fv_r <= ftag.vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  assign gt   = x_r > PI_X;
  assign lt   = x_r < NPI_X;
  assign diff = gt ? (x_r - PI_P1) : (NPI_M1 - x_r);

  always_comb begin
    if (gt) begin
      mode_nxt = scp_pkg::MODE_POS;
    end else if (lt) begin
      mode_nxt = scp_pkg::MODE_NEG;
    end else begin
      mode_nxt = scp_pkg::MODE_KEEP;
    end
    u_nxt = UW'(diff);
  end

  always_ff @(posedge clk) begin
    u_r     <= u_nxt;
    mode1_r <= mode_nxt;
    xs1_r   <= x_r[30:0];
  end

  assign tag_c[0] = '{vld: v1_r, mode: mode1_r, xs: xs1_r};
  assign rem_c[0] = u_r;

  // remainder mod 2pi, most significant quotient bit first
  for (genvar i = 0; i < NQ; i++) begin : g_cell
    scp_cell #(
      .UW (UW),
      .K  (NQ - 1 - i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tag_i (tag_c[i]),
      .rem_i (rem_c[i]),
      .tag_o (tag_c[i+1]),
      .rem_o (rem_c[i+1])
    );
  end

  assign ftag  = tag_c[NQ];
  assign rem_f = rem_c[NQ][30:0];
  assign lo    = rem_f < scp_pkg::K_FOLD;
  assign dcm   = lo ? (scp_pkg::K_FOLD - rem_f) : (rem_f - scp_pkg::K_FOLD);

  // angle above pi lands at rem - fold, below -pi at fold - rem
  always_comb begin
    case (ftag.mode)
      scp_pkg::MODE_POS: begin
        neg_nxt = lo;
        m_nxt   = dcm[29:0];
      end
      scp_pkg::MODE_NEG: begin
        neg_nxt = ~lo && (rem_f != scp_pkg::K_FOLD);
        m_nxt   = dcm[29:0];
      end
      default: begin
        neg_nxt = ftag.xs[30];
        m_nxt   = ftag.xs[30] ? 30'(-ftag.xs) : ftag.xs[29:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    neg_r <= neg_nxt;
  end

  scp_poly #(
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (fv_r),
    .m_i     (m_r),
    .neg_i   (neg_r),
    .vld_o   (out_valid),
    .value_o (out_value)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("result strobe missing after accepted beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without accepted beat");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ftag.vld |-> (rem_c[NQ] < UW'(scp_pkg::K_TWO_PI)))
    else $error("reduction remainder not below 2pi");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    fv_r |-> (m_r <= 30'(scp_pkg::K_PI)))
    else $error("reduced angle magnitude above pi");

endmodule
